/* sv/wrt_pkg.sv */
package wrt_pkg;

   localparam int HALF_LEN = 8;
   localparam int RING_LEN = 2 * HALF_LEN;
   localparam int PTR_W    = $clog2(RING_LEN);
   localparam int CNT_W    = $clog2(HALF_LEN + 1);
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int DCNT_W   = $clog2(SUM_W);
   localparam int TREND_W  = 17;

   // sequencer steps
   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_SCAN  = 3'd1,
      S_CHECK = 3'd2,
      S_DIV   = 3'd3,
      S_EMIT  = 3'd4
   } step_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_LOAD  = 3'd0,
      OP_SCAN  = 3'd1,
      OP_SETUP = 3'd2,
      OP_DIV   = 3'd3,
      OP_EMIT  = 3'd4
   } op_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_REQ       = 3'd0,
      COND_SCAN_LAST = 3'd1,
      COND_EMPTY     = 3'd2,
      COND_DIV_LAST  = 3'd3,
      COND_OUT_FREE  = 3'd4
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ctrl_type;

   // microcode rom
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type word;
      unique case (step)
         S_IDLE:  word = '{OP_LOAD,  COND_REQ,       S_SCAN,  S_IDLE};
         S_SCAN:  word = '{OP_SCAN,  COND_SCAN_LAST, S_CHECK, S_SCAN};
         S_CHECK: word = '{OP_SETUP, COND_EMPTY,     S_EMIT,  S_DIV};
         S_DIV:   word = '{OP_DIV,   COND_DIV_LAST,  S_EMIT,  S_DIV};
         S_EMIT:  word = '{OP_EMIT,  COND_OUT_FREE,  S_IDLE,  S_EMIT};
         default: word = '{OP_LOAD,  COND_REQ,       S_SCAN,  S_IDLE};
      endcase
      return word;
   endfunction

endpackage

/* sv/window_rise_trend.sv */
// sequence: the load step ends at the req transfer, then 2*HALF_LEN scan steps, 1 check
// step, SUM_W divide steps and 1 emit step; the divide steps are skipped when a half is
// empty, and the emit step waits until the result register is free; the divider is a
// one-bit-per-cycle restoring divider
// a new sample is taken only in the idle step, after the previous item is emitted; the
// result register lets the next item start while a result waits for rsp_ready
// reset: synchronous, active high; clears pointer, present bits, sequencer and rsp_valid
module window_rise_trend (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [wrt_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_sample_missing,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [wrt_pkg::TREND_W-1:0]  rsp_trend,
   output logic                                rsp_trend_valid
);

   // sequencer
   wrt_pkg::step_type step_ff, step_in;
   wrt_pkg::ctrl_type ctrl;
   logic              cond_hit;

   // ring storage, present bits live in flops cleared by reset
   logic signed [wrt_pkg::SAMPLE_W-1:0] ring_ff [wrt_pkg::RING_LEN];
   logic [wrt_pkg::RING_LEN-1:0]        present_ff, present_in;
   logic [wrt_pkg::PTR_W-1:0]           wp_ff, wp_in;
   logic [wrt_pkg::PTR_W-1:0]           rd_ff, rd_in;
   logic [wrt_pkg::PTR_W-1:0]           k_ff, k_in;
   logic                                ring_we;

   // scan accumulators
   logic signed [wrt_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [wrt_pkg::CNT_W-1:0]           old_cnt_ff, old_cnt_in;
   logic [wrt_pkg::CNT_W-1:0]           new_cnt_ff, new_cnt_in;
   logic signed [wrt_pkg::SAMPLE_W-1:0] max_ff, max_in;

   // divider
   logic [wrt_pkg::SUM_W-1:0]  quo_ff, quo_in;
   logic [wrt_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [wrt_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic                       neg_ff, neg_in;
   logic                       ok_ff, ok_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [wrt_pkg::TREND_W-1:0] rsp_trend_ff, rsp_trend_in;
   logic                               rsp_ok_ff, rsp_ok_in;
   logic                               out_load;

   // datapath helpers
   logic signed [wrt_pkg::SAMPLE_W-1:0] rd_val;
   logic                                rd_present;
   logic                                in_old_half;
   logic [wrt_pkg::PTR_W-1:0]           wp_next;
   logic [wrt_pkg::PTR_W-1:0]           rd_next;
   logic [wrt_pkg::SUM_W-1:0]           sum_mag;
   logic [wrt_pkg::CNT_W:0]             rem_shift;
   logic                                rem_ge;
   logic [wrt_pkg::TREND_W-1:0]         quo_short;
   logic [wrt_pkg::TREND_W-1:0]         mean;
   logic [wrt_pkg::TREND_W-1:0]         trend_calc;
   logic                                half_empty;
   logic                                out_free;

   assign ctrl = wrt_pkg::ucode(step_ff);

   // ring read at the walking pointer
   assign rd_val      = ring_ff[rd_ff];
   assign rd_present  = present_ff[rd_ff];
   assign in_old_half = (k_ff < wrt_pkg::PTR_W'(wrt_pkg::HALF_LEN));

   // pointer wrap at ring length, which need not be a power of two
   assign wp_next = (wp_ff == wrt_pkg::PTR_W'(wrt_pkg::RING_LEN - 1)) ?
                    '0 : wp_ff + wrt_pkg::PTR_W'(1);
   assign rd_next = (rd_ff == wrt_pkg::PTR_W'(wrt_pkg::RING_LEN - 1)) ?
                    '0 : rd_ff + wrt_pkg::PTR_W'(1);

   // magnitude of the older-half sum for the unsigned divider
   assign sum_mag = sum_ff[wrt_pkg::SUM_W-1] ? (~sum_ff + wrt_pkg::SUM_W'(1)) : sum_ff;

   // one restoring step: shift in next dividend bit, subtract count if it fits
   assign rem_shift = {rem_ff, quo_ff[wrt_pkg::SUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, old_cnt_ff});

   // signed truncated mean, then the rise over it
   assign quo_short  = quo_ff[wrt_pkg::TREND_W-1:0];
   assign mean       = neg_ff ? (~quo_short + wrt_pkg::TREND_W'(1)) : quo_short;
   assign trend_calc = {1'b0, max_ff} - mean;

   assign half_empty = (old_cnt_ff == '0) || (new_cnt_ff == '0);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // jump condition select
   always_comb begin
      unique case (ctrl.cond)
         wrt_pkg::COND_REQ:       cond_hit = req_valid;
         wrt_pkg::COND_SCAN_LAST: cond_hit = (k_ff == wrt_pkg::PTR_W'(wrt_pkg::RING_LEN - 1));
         wrt_pkg::COND_EMPTY:     cond_hit = half_empty;
         wrt_pkg::COND_DIV_LAST:  cond_hit = (dcnt_ff == wrt_pkg::DCNT_W'(wrt_pkg::SUM_W - 1));
         wrt_pkg::COND_OUT_FREE:  cond_hit = out_free;
         default:                 cond_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= wrt_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // next step and datapath controls from the control word
   always_comb begin
      step_in      = cond_hit ? ctrl.on_true : ctrl.on_false;
      req_ready    = (ctrl.op == wrt_pkg::OP_LOAD);
      ring_we      = 1'b0;
      present_in   = present_ff;
      wp_in        = wp_ff;
      rd_in        = rd_ff;
      k_in         = k_ff;
      sum_in       = sum_ff;
      old_cnt_in   = old_cnt_ff;
      new_cnt_in   = new_cnt_ff;
      max_in       = max_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      ok_in        = ok_ff;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_trend_in = rsp_trend_ff;
      rsp_ok_in    = rsp_ok_ff;

      unique case (ctrl.op)
         wrt_pkg::OP_LOAD: begin
            if (cond_hit) begin
               // store sample, advance pointer, start walk at the oldest entry
               ring_we           = 1'b1;
               present_in[wp_ff] = !req_sample_missing;
               wp_in             = wp_next;
               rd_in             = wp_next;
               k_in              = '0;
               sum_in            = '0;
               old_cnt_in        = '0;
               new_cnt_in        = '0;
               max_in            = '0;
            end
         end
         wrt_pkg::OP_SCAN: begin
            if (rd_present) begin
               if (in_old_half) begin
                  sum_in     = sum_ff + {{(wrt_pkg::SUM_W - wrt_pkg::SAMPLE_W)
                                          {rd_val[wrt_pkg::SAMPLE_W-1]}}, rd_val};
                  old_cnt_in = old_cnt_ff + wrt_pkg::CNT_W'(1);
               end else begin
                  if (rd_val > max_ff) begin
                     max_in = rd_val;
                  end
                  new_cnt_in = new_cnt_ff + wrt_pkg::CNT_W'(1);
               end
            end
            rd_in = rd_next;
            k_in  = k_ff + wrt_pkg::PTR_W'(1);
         end
         wrt_pkg::OP_SETUP: begin
            ok_in   = !half_empty;
            neg_in  = sum_ff[wrt_pkg::SUM_W-1];
            quo_in  = sum_mag;
            rem_in  = '0;
            dcnt_in = '0;
         end
         wrt_pkg::OP_DIV: begin
            rem_in  = rem_ge ? wrt_pkg::CNT_W'(rem_shift - {1'b0, old_cnt_ff})
                             : rem_shift[wrt_pkg::CNT_W-1:0];
            quo_in  = {quo_ff[wrt_pkg::SUM_W-2:0], rem_ge};
            dcnt_in = dcnt_ff + wrt_pkg::DCNT_W'(1);
         end
         wrt_pkg::OP_EMIT: begin
            // load the result register once the previous transfer has gone
            if (cond_hit) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_trend_in = ok_ff ? trend_calc : '0;
               rsp_ok_in    = ok_ff;
            end
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         present_ff   <= present_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_ff[wp_ff] <= req_sample_missing ? '0 : req_sample;
      end
      rd_ff        <= rd_in;
      k_ff         <= k_in;
      sum_ff       <= sum_in;
      old_cnt_ff   <= old_cnt_in;
      new_cnt_ff   <= new_cnt_in;
      max_ff       <= max_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      neg_ff       <= neg_in;
      ok_ff        <= ok_in;
      rsp_trend_ff <= rsp_trend_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_trend       = rsp_trend_ff;
   assign rsp_trend_valid = rsp_ok_ff;

   // a transfer in always starts a fresh walk
   a_load_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (step_ff == wrt_pkg::S_SCAN) && (k_ff == '0))
      else $error("transfer in did not start the ring walk");

   // present bit follows the missing flag of the stored sample
   a_present_written: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (present_ff[$past(wp_ff)] == !$past(req_sample_missing)))
      else $error("present bit not written from missing flag");

   // the result register is never overwritten while a result waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   // a valid trend needs both halves populated
   a_valid_needs_counts: assert property (@(posedge clock) disable iff (reset)
      (out_load && ok_ff) |-> (old_cnt_ff != '0) && (new_cnt_ff != '0))
      else $error("trend marked valid with an empty half");

endmodule
